### hw/rtl/aarm_pkg.sv
// aarm_pkg: shared types, constants and helper functions of the axis-angle rotation matrix block
// no dependencies
package aarm_pkg;

  localparam int FracBitsDef    = 14;
  localparam int CordicStepsDef = 16;
  localparam int MaxSteps       = 32;
  localparam int CW             = 34;
  localparam int AW             = 17;
  localparam int PW             = 68;
  localparam int SW             = 72;
  localparam logic signed [CW-1:0] CordicGain = CW'(64'sh26DD3B6A);
  localparam logic signed [CW-1:0] QOne       = CW'(64'sh40000000);

  typedef struct packed {
    logic [15:0]        angle;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } out_word_t;

  typedef struct packed {
    logic                 vld;
    logic                 flip;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic signed [15:0]   ax;
    logic signed [15:0]   ay;
    logic signed [15:0]   az;
  } cordic_word_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // q30 to q(f), round half up, saturate
  function automatic logic [15:0] to_out(input logic signed [SW-1:0] v, input int f);
    logic signed [SW-1:0] w;
    logic signed [SW-1:0] one;
    int sh;
    sh  = 30 - f;
    one = SW'(1) <<< f;
    w   = v;
    if (sh > 0) begin
      w = (w + (SW'(1) <<< (sh - 1))) >>> sh;
    end
    if (w > one) w = one;
    if (w < -one) w = -one;
    if (w > SW'(32767)) w = SW'(32767);
    if (w < -SW'(32768)) w = -SW'(32768);
    return w[15:0];
  endfunction

endpackage

### hw/rtl/axis_angle_rotation_matrix_top.sv
// axis_angle_rotation_matrix_top: rodrigues rotation matrix from binary angle and unit axis
// depends on aarm_pkg, aarm_cordic_cell, aarm_rodrigues
//
//  channel | ports                        | word
//  input   | in_valid in_ready in_data    | angle, axis_x, axis_y, axis_z
//  result  | out_valid out_ready out_data | m00 .. m22
//
// one word accepted per cycle while the result is not stalled; the pipeline registers are the
// entry register, one cordic cell per step and three product and rounding stages
// synchronous active-low reset clears the stage valid bits only
// a stalled result holds the whole pipeline; in_ready = !out_valid || out_ready
module axis_angle_rotation_matrix_top #(
  parameter int FRAC_BITS    = aarm_pkg::FracBitsDef,
  parameter int CORDIC_STEPS = aarm_pkg::CordicStepsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  aarm_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output aarm_pkg::out_word_t out_data
);
  import aarm_pkg::*;

  localparam int NC = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;

  logic         en;
  cordic_word_t c_s [NC+1];
  cordic_word_t e_r, e_nxt;
  logic signed [CW-1:0] z0;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // quarter-turn fold
  always_comb begin
    z0          = CW'($signed({in_data.angle, 16'b0}));
    e_nxt.vld   = in_valid;
    e_nxt.x     = CordicGain;
    e_nxt.y     = '0;
    e_nxt.ax    = in_data.axis_x;
    e_nxt.ay    = in_data.axis_y;
    e_nxt.az    = in_data.axis_z;
    e_nxt.flip  = 1'b0;
    e_nxt.z     = z0;
    if (z0 > QOne) begin
      e_nxt.z    = z0 - (QOne <<< 1);
      e_nxt.flip = 1'b1;
    end else if (z0 < -QOne) begin
      e_nxt.z    = z0 + (QOne <<< 1);
      e_nxt.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r.vld <= 1'b0;
    end else if (en) begin
      e_r <= e_nxt;
    end
  end

  assign c_s[0] = e_r;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    aarm_cordic_cell #(.Step(i)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .d_in (c_s[i]),
      .d_out(c_s[i+1])
    );
  end

  aarm_rodrigues #(.FracBits(FRAC_BITS)) u_rod (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .d_in    (c_s[NC]),
    .out_vld (out_valid),
    .out_word(out_data)
  );
endmodule

### hw/rtl/aarm_cordic_cell.sv
// aarm_cordic_cell: one rotation-mode cordic iteration with its register
// depends on aarm_pkg
module aarm_cordic_cell #(
  parameter int Step = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  aarm_pkg::cordic_word_t d_in,
  output aarm_pkg::cordic_word_t d_out
);
  import aarm_pkg::*;

  localparam logic signed [CW-1:0] Atan = CW'(atan_bam(5'(Step)));

  cordic_word_t w_r, w_nxt;

  always_comb begin
    w_nxt = d_in;
    if (!d_in.z[CW-1]) begin
      w_nxt.x = d_in.x - (d_in.y >>> Step);
      w_nxt.y = d_in.y + (d_in.x >>> Step);
      w_nxt.z = d_in.z - Atan;
    end else begin
      w_nxt.x = d_in.x + (d_in.y >>> Step);
      w_nxt.y = d_in.y - (d_in.x >>> Step);
      w_nxt.z = d_in.z + Atan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r.vld <= 1'b0;
    end else if (en) begin
      w_r <= w_nxt;
    end
  end

  assign d_out = w_r;
endmodule

### hw/rtl/aarm_rodrigues.sv
// aarm_rodrigues: three-stage product, sum, round and saturate pipeline after the cordic row
// depends on aarm_pkg
module aarm_rodrigues #(
  parameter int FracBits = aarm_pkg::FracBitsDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  aarm_pkg::cordic_word_t d_in,
  output logic                   out_vld,
  output aarm_pkg::out_word_t    out_word
);
  import aarm_pkg::*;

  // stage 1
  logic                 v1_r;
  logic signed [CW-1:0] s_r, t_r;
  logic signed [AW-1:0] am_r [6];
  logic signed [CW-1:0] dq_r [6];
  // stage 2
  logic                 v2_r;
  logic signed [PW-1:0] ps_r [6];
  logic signed [PW-1:0] pt_r [6];
  // stage 3
  logic                 v3_r;
  out_word_t            o_r;

  logic signed [CW-1:0] s_nxt, c_nxt;
  logic signed [31:0]   xx, yy, zz, xy, xz, yz;
  logic signed [CW+AW-1:0] mps [6];
  logic signed [2*CW-1:0]  mpt [6];
  logic signed [SW-1:0] e [9];
  logic signed [SW-1:0] qone_w;

  always_comb begin
    s_nxt = d_in.flip ? -d_in.y : d_in.y;
    c_nxt = d_in.flip ? -d_in.x : d_in.x;
    xx = 32'(d_in.ax) * 32'(d_in.ax);
    yy = 32'(d_in.ay) * 32'(d_in.ay);
    zz = 32'(d_in.az) * 32'(d_in.az);
    xy = 32'(d_in.ax) * 32'(d_in.ay);
    xz = 32'(d_in.ax) * 32'(d_in.az);
    yz = 32'(d_in.ay) * 32'(d_in.az);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r      <= s_nxt;
      t_r      <= QOne - c_nxt;
      am_r[0]  <= -AW'(d_in.az);
      am_r[1]  <= AW'(d_in.ay);
      am_r[2]  <= AW'(d_in.az);
      am_r[3]  <= -AW'(d_in.ax);
      am_r[4]  <= -AW'(d_in.ay);
      am_r[5]  <= AW'(d_in.ax);
      dq_r[0]  <= -(CW'(yy) + CW'(zz));
      dq_r[1]  <= -(CW'(xx) + CW'(zz));
      dq_r[2]  <= -(CW'(xx) + CW'(yy));
      dq_r[3]  <= CW'(xy);
      dq_r[4]  <= CW'(xz);
      dq_r[5]  <= CW'(yz);
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      mps[k] = (CW+AW)'(s_r) * (CW+AW)'(am_r[k]);
      mpt[k] = (2*CW)'(t_r) * (2*CW)'(dq_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        ps_r[k] <= PW'(mps[k] >>> FracBits);
        pt_r[k] <= PW'(mpt[k] >>> (2 * FracBits));
      end
    end
  end

  // ps order: -az, ay, az, -ax, -ay, ax; pt order: d0 d1 d2 xy xz yz
  always_comb begin
    qone_w = SW'(QOne);
    e[0] = qone_w + SW'(pt_r[0]);
    e[1] = SW'(ps_r[0]) + SW'(pt_r[3]);
    e[2] = SW'(ps_r[1]) + SW'(pt_r[4]);
    e[3] = SW'(ps_r[2]) + SW'(pt_r[3]);
    e[4] = qone_w + SW'(pt_r[1]);
    e[5] = SW'(ps_r[3]) + SW'(pt_r[5]);
    e[6] = SW'(ps_r[4]) + SW'(pt_r[4]);
    e[7] = SW'(ps_r[5]) + SW'(pt_r[5]);
    e[8] = qone_w + SW'(pt_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_r.m00 <= to_out(e[0], FracBits);
      o_r.m01 <= to_out(e[1], FracBits);
      o_r.m02 <= to_out(e[2], FracBits);
      o_r.m10 <= to_out(e[3], FracBits);
      o_r.m11 <= to_out(e[4], FracBits);
      o_r.m12 <= to_out(e[5], FracBits);
      o_r.m20 <= to_out(e[6], FracBits);
      o_r.m21 <= to_out(e[7], FracBits);
      o_r.m22 <= to_out(e[8], FracBits);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= d_in.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign out_vld  = v3_r;
  assign out_word = o_r;
endmodule

### hw/rtl/aarm_checker.sv
// aarm_checker: port-level assertions for the rotation matrix block, bound to the top level
// depends on aarm_pkg, axis_angle_rotation_matrix_top
module aarm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input aarm_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input aarm_pkg::out_word_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result word changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input word withdrawn or changed while waiting");
endmodule

bind axis_angle_rotation_matrix_top aarm_checker u_aarm_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

### test/axis_angle_rotation_matrix_top_test.sv
// axis_angle_rotation_matrix_top_test: self-checking bench for the rotation matrix block
// depends on aarm_pkg and axis_angle_rotation_matrix_top; predicts each matrix with a
// bit-exact cordic and rodrigues model and compares the result words in order
module axis_angle_rotation_matrix_top_test;
  import aarm_pkg::*;

  localparam int Frac = FracBitsDef;
  localparam int Steps = CordicStepsDef;
  localparam int Latency = Steps + 4;
  localparam longint CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;

  in_word_t pending_words[$];
  out_word_t expected_matrices[$];
  int mismatches = 0;
  int checked = 0;
  longint cycle = 0;
  bit calm = 0;
  bit hold_off = 0;
  int send_gap = 0;
  int recv_gap = 0;

  axis_angle_rotation_matrix_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [15:0] round_sat(longint v);
    longint w;
    longint one;
    one = longint'(1) <<< Frac;
    w = (v + (longint'(1) <<< (29 - Frac))) >>> (30 - Frac);
    if (w > one) w = one;
    if (w < -one) w = -one;
    return w[15:0];
  endfunction

  function automatic out_word_t rotation_matrix(in_word_t w);
    longint z, x, y, dx, dy, s, c, t, ax, ay, az, q1;
    logic [31:0] atan_tab [32];
    bit flip;
    out_word_t m;
    atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                 81, 41, 20, 10, 5, 3, 1, 1, 0};
    z = longint'({w.angle, 16'h0000});
    if (z >= 64'sh80000000) z -= 64'sh100000000;
    flip = 0;
    if (z > 64'sh40000000) begin
      z -= 64'sh80000000;
      flip = 1;
    end else if (z < -64'sh40000000) begin
      z += 64'sh80000000;
      flip = 1;
    end
    x = 64'sh26DD3B6A;
    y = 0;
    for (int i = 0; i < Steps; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_tab[i]);
      end else begin
        x += dx; y -= dy; z += longint'(atan_tab[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y; c = x;
    q1 = longint'(1) <<< 30;
    t = q1 - c;
    ax = w.axis_x; ay = w.axis_y; az = w.axis_z;
    m.m00 = round_sat(q1 + ((t * -(ay*ay + az*az)) >>> (2*Frac)));
    m.m01 = round_sat(((s * -az) >>> Frac) + ((t * ax*ay) >>> (2*Frac)));
    m.m02 = round_sat(((s * ay) >>> Frac) + ((t * ax*az) >>> (2*Frac)));
    m.m10 = round_sat(((s * az) >>> Frac) + ((t * ax*ay) >>> (2*Frac)));
    m.m11 = round_sat(q1 + ((t * -(ax*ax + az*az)) >>> (2*Frac)));
    m.m12 = round_sat(((s * -ax) >>> Frac) + ((t * ay*az) >>> (2*Frac)));
    m.m20 = round_sat(((s * -ay) >>> Frac) + ((t * ax*az) >>> (2*Frac)));
    m.m21 = round_sat(((s * ax) >>> Frac) + ((t * ay*az) >>> (2*Frac)));
    m.m22 = round_sat(q1 + ((t * -(ax*ax + ay*ay)) >>> (2*Frac)));
    return m;
  endfunction

  function automatic in_word_t mk(int a, int x, int y, int z);
    in_word_t w;
    w.angle = a[15:0]; w.axis_x = x[15:0]; w.axis_y = y[15:0]; w.axis_z = z[15:0];
    return w;
  endfunction

  function automatic int unit_comp();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  // driver
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_matrices.push_back(rotation_matrix(in_data));
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_words.pop_front();
          if (!calm && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t exp_m;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        checked <= checked + 1;
        if (expected_matrices.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result word %h", out_data);
        end else begin
          exp_m = expected_matrices.pop_front();
          if (exp_m !== out_data) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("mismatch: expected %h got %h", exp_m, out_data);
          end
        end
      end
      if (hold_off) out_ready <= 1'b0;
      else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 9);
      end
    end
  end

  // long receiver stall
  initial begin
    int held;
    held = 0;
    wait (rst_n);
    repeat (300) @(posedge clk);
    hold_off <= 1'b1;
    while (held < 200) begin
      @(posedge clk);
      held++;
    end
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (cycle > CycleLimit) begin
      $display("timeout after %0d cycles", cycle);
      $display("** axis_angle_rotation_matrix_top: FAILED **");
      $finish;
    end
  end

  initial begin
    int ang[8];
    int t;
    ang = '{0, 16384, 32768, 49152, 65535, 16383, 16385, 49153};
    for (int i = 0; i < 8; i++) pending_words.push_back(mk(ang[i], 0, 0, 16384));
    pending_words.push_back(mk(8192, 16384, 0, 0));
    pending_words.push_back(mk(40000, 0, 16384, 0));
    pending_words.push_back(mk(12345, -16384, 0, 0));
    pending_words.push_back(mk(20000, 0, -16384, 0));
    pending_words.push_back(mk(30000, 0, 0, -16384));
    pending_words.push_back(mk(32768, 9459, 9459, 9459));
    pending_words.push_back(mk(16384, 32767, 32767, 32767));
    pending_words.push_back(mk(49152, -32768, -32768, -32768));
    pending_words.push_back(mk(32768, -32768, 32767, 0));
    pending_words.push_back(mk(0, -32768, -32768, -32768));
    pending_words.push_back(mk(21845, 16384, 16384, 16384));
    for (int i = 0; i < 900; i++) begin
      if ($urandom_range(0, 3) == 0)
        pending_words.push_back(in_word_t'({$urandom, $urandom}));
      else
        pending_words.push_back(mk($urandom_range(0, 65535), unit_comp(), unit_comp(),
                                   unit_comp()));
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_words.size() > 0 || in_valid) begin
      @(posedge clk);
      if (pending_words.size() < 150) calm <= 1'b1;
    end
    while (expected_matrices.size() > 0 || hold_off) @(posedge clk);
    t = 0;
    while (t < Latency + 10) begin
      @(posedge clk);
      t++;
    end
    $display("checked %0d rotation matrices over %0d cycles, incl. directed angles,",
             checked, cycle);
    $display("out-of-range axes, random stalls and a long result hold-off");
    if (mismatches == 0 && expected_matrices.size() == 0)
      $display("** axis_angle_rotation_matrix_top: PASSED **");
    else
      $display("** axis_angle_rotation_matrix_top: FAILED **");
    $finish;
  end

endmodule
